/* hw/rtl/sdcp_pkg.sv */
`default_nettype none

package sdcp_pkg;

    localparam int LINE_CAPACITY = 64;
    localparam int LEN_W = $clog2(LINE_CAPACITY);

    localparam int DUTY_W = 16;
    localparam int PCT_W = 7;
    localparam int PROD_W = DUTY_W + PCT_W;

    // x / 100 == (x / 4) / 25, and (y * DIV_RECIP) >> DIV_SHIFT == y / 25 for y < 2**21
    localparam int QUOT_IN_W = PROD_W - 2;
    localparam int DIV_SHIFT = 26;
    localparam int RECIP_W = 22;
    localparam logic [RECIP_W-1:0] DIV_RECIP = 22'd2684355;

    localparam logic [1:0] REPLY_NONE = 2'd0;
    localparam logic [1:0] REPLY_OK = 2'd1;
    localparam logic [1:0] REPLY_SYNTAX = 2'd2;
    localparam logic [1:0] REPLY_LONG = 2'd3;

    localparam logic [1:0] CFG_PWM_TOP = 2'd0;
    localparam logic [1:0] CFG_PWM_LIMIT = 2'd1;
    localparam logic [1:0] CFG_TIMEOUT = 2'd2;

    localparam logic [DUTY_W-1:0] PWM_TOP_RESET = 16'd1599;
    localparam logic [PCT_W-1:0] PWM_LIMIT_RESET = 7'd100;
    localparam logic [15:0] TIMEOUT_RESET = 16'd500;

    typedef struct packed {
        logic [1:0] reply;
        logic ok;
        logic stop;
        logic left_neg;
        logic left_nz;
        logic [PROD_W-1:0] left_prod;
        logic right_neg;
        logic right_nz;
        logic [PROD_W-1:0] right_prod;
    } sdcp_stage_t;

    typedef logic [3:0][DUTY_W-1:0] duty_set_t;

endpackage

`default_nettype wire

/* hw/rtl/sdcp_parse.sv */
`default_nettype none

module sdcp_parse
    import sdcp_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              accept,
    input  wire logic              advance,
    input  wire logic              req_type,
    input  wire logic [7:0]        rx_byte,
    input  wire logic [DUTY_W-1:0] pwm_top,
    input  wire logic [PCT_W-1:0]  pwm_limit,
    input  wire logic [15:0]       timeout_ms,
    output logic                   stage_valid,
    output sdcp_stage_t            stage
);

    localparam logic [3:0] PH_START = 4'd0;
    localparam logic [3:0] PH_PRE_LEFT = 4'd1;
    localparam logic [3:0] PH_LEFT_SIGN = 4'd2;
    localparam logic [3:0] PH_LEFT_DIG = 4'd3;
    localparam logic [3:0] PH_POST_LEFT = 4'd4;
    localparam logic [3:0] PH_PRE_RIGHT = 4'd5;
    localparam logic [3:0] PH_RIGHT_SIGN = 4'd6;
    localparam logic [3:0] PH_RIGHT_DIG = 4'd7;
    localparam logic [3:0] PH_DONE = 4'd8;
    localparam logic [3:0] PH_FAIL = 4'd9;

    localparam logic [7:0] CH_NUL = 8'd0;
    localparam logic [7:0] CH_TAB = 8'd9;
    localparam logic [7:0] CH_LF = 8'd10;
    localparam logic [7:0] CH_VT = 8'd11;
    localparam logic [7:0] CH_FF = 8'd12;
    localparam logic [7:0] CH_CR = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_PLUS = 8'd43;
    localparam logic [7:0] CH_MINUS = 8'd45;
    localparam logic [7:0] CH_ZERO = 8'd48;
    localparam logic [7:0] CH_NINE = 8'd57;
    localparam logic [7:0] CH_UP_L = 8'd76;
    localparam logic [7:0] CH_UP_R = 8'd82;
    localparam logic [7:0] CH_LO_L = 8'd108;
    localparam logic [7:0] CH_LO_R = 8'd114;

    localparam logic [PCT_W-1:0] PCT_MAX = 7'd100;
    localparam logic [LEN_W-1:0] LEN_LAST = LEN_W'(LINE_CAPACITY - 1);

    function automatic logic [PCT_W-1:0] add_digit(input logic [PCT_W-1:0] mag,
                                                   input logic [7:0] b);
        logic [9:0] v;
        v = 10'(mag) * 10'd10 + 10'(b - CH_ZERO);
        return (v > 10'(PCT_MAX)) ? PCT_MAX : v[PCT_W-1:0];
    endfunction

    logic [3:0]       phase_reg, phase_next;
    logic             upper_reg, upper_next;
    logic             ended_reg, ended_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic             lneg_reg, lneg_next;
    logic [PCT_W-1:0] lmag_reg, lmag_next;
    logic             rneg_reg, rneg_next;
    logic [PCT_W-1:0] rmag_reg, rmag_next;
    logic [15:0]      elapsed_reg, elapsed_next;
    logic             valid_reg;
    sdcp_stage_t      stage_reg, stage_next;

    logic             blank;
    logic             digit;
    logic [7:0]       r_letter;
    logic [PCT_W-1:0] pct;
    logic [PCT_W-1:0] lim_l;
    logic [PCT_W-1:0] lim_r;

    assign blank = (rx_byte == CH_SPACE) || (rx_byte == CH_TAB) || (rx_byte == CH_VT)
                || (rx_byte == CH_FF) || (rx_byte == CH_LF) || (rx_byte == CH_CR);
    assign digit = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
    assign r_letter = upper_reg ? CH_UP_R : CH_LO_R;

    assign pct = (pwm_limit > PCT_MAX) ? PCT_MAX : pwm_limit;
    assign lim_l = (lmag_reg < pct) ? lmag_reg : pct;
    assign lim_r = (rmag_reg < pct) ? rmag_reg : pct;

    always_comb
    begin
        phase_next = phase_reg;
        upper_next = upper_reg;
        ended_next = ended_reg;
        len_next = len_reg;
        lneg_next = lneg_reg;
        lmag_next = lmag_reg;
        rneg_next = rneg_reg;
        rmag_next = rmag_reg;
        elapsed_next = elapsed_reg;
        stage_next.reply = REPLY_NONE;
        stage_next.ok = 1'b0;
        stage_next.left_neg = lneg_reg;
        stage_next.left_nz = (lmag_reg != '0);
        stage_next.left_prod = PROD_W'(pwm_top) * PROD_W'(lim_l);
        stage_next.right_neg = rneg_reg;
        stage_next.right_nz = (rmag_reg != '0);
        stage_next.right_prod = PROD_W'(pwm_top) * PROD_W'(lim_r);

        if (req_type)
        begin
            if (elapsed_reg != 16'hFFFF)
            begin
                elapsed_next = elapsed_reg + 16'd1;
            end
        end
        else if ((rx_byte == CH_CR) || (rx_byte == CH_LF))
        begin
            if (len_reg != '0)
            begin
                if ((phase_reg == PH_RIGHT_DIG) || (phase_reg == PH_DONE))
                begin
                    stage_next.ok = 1'b1;
                    stage_next.reply = REPLY_OK;
                    elapsed_next = '0;
                end
                else
                begin
                    stage_next.reply = REPLY_SYNTAX;
                end
                phase_next = PH_START;
                upper_next = 1'b0;
                ended_next = 1'b0;
                len_next = '0;
                lneg_next = 1'b0;
                lmag_next = '0;
                rneg_next = 1'b0;
                rmag_next = '0;
            end
        end
        else if (len_reg < LEN_LAST)
        begin
            len_next = len_reg + LEN_W'(1);
            if (!ended_reg)
            begin
                if (rx_byte == CH_NUL)
                begin
                    ended_next = 1'b1;
                end
                else
                begin
                    unique case (phase_reg)
                        PH_START:
                        begin
                            if (rx_byte == CH_UP_L)
                            begin
                                upper_next = 1'b1;
                                phase_next = PH_PRE_LEFT;
                            end
                            else if (rx_byte == CH_LO_L)
                            begin
                                upper_next = 1'b0;
                                phase_next = PH_PRE_LEFT;
                            end
                            else
                            begin
                                phase_next = PH_FAIL;
                            end
                        end
                        PH_PRE_LEFT:
                        begin
                            if (blank)
                            begin
                                phase_next = PH_PRE_LEFT;
                            end
                            else if (rx_byte == CH_MINUS)
                            begin
                                lneg_next = 1'b1;
                                phase_next = PH_LEFT_SIGN;
                            end
                            else if (rx_byte == CH_PLUS)
                            begin
                                phase_next = PH_LEFT_SIGN;
                            end
                            else if (digit)
                            begin
                                lmag_next = add_digit('0, rx_byte);
                                phase_next = PH_LEFT_DIG;
                            end
                            else
                            begin
                                phase_next = PH_FAIL;
                            end
                        end
                        PH_LEFT_SIGN:
                        begin
                            if (digit)
                            begin
                                lmag_next = add_digit('0, rx_byte);
                                phase_next = PH_LEFT_DIG;
                            end
                            else
                            begin
                                phase_next = PH_FAIL;
                            end
                        end
                        PH_LEFT_DIG:
                        begin
                            if (digit)
                            begin
                                lmag_next = add_digit(lmag_reg, rx_byte);
                            end
                            else if (blank)
                            begin
                                phase_next = PH_POST_LEFT;
                            end
                            else if (rx_byte == r_letter)
                            begin
                                phase_next = PH_PRE_RIGHT;
                            end
                            else
                            begin
                                phase_next = PH_FAIL;
                            end
                        end
                        PH_POST_LEFT:
                        begin
                            if (!blank)
                            begin
                                phase_next = (rx_byte == r_letter) ? PH_PRE_RIGHT : PH_FAIL;
                            end
                        end
                        PH_PRE_RIGHT:
                        begin
                            if (blank)
                            begin
                                phase_next = PH_PRE_RIGHT;
                            end
                            else if (rx_byte == CH_MINUS)
                            begin
                                rneg_next = 1'b1;
                                phase_next = PH_RIGHT_SIGN;
                            end
                            else if (rx_byte == CH_PLUS)
                            begin
                                phase_next = PH_RIGHT_SIGN;
                            end
                            else if (digit)
                            begin
                                rmag_next = add_digit('0, rx_byte);
                                phase_next = PH_RIGHT_DIG;
                            end
                            else
                            begin
                                phase_next = PH_FAIL;
                            end
                        end
                        PH_RIGHT_SIGN:
                        begin
                            if (digit)
                            begin
                                rmag_next = add_digit('0, rx_byte);
                                phase_next = PH_RIGHT_DIG;
                            end
                            else
                            begin
                                phase_next = PH_FAIL;
                            end
                        end
                        PH_RIGHT_DIG:
                        begin
                            if (digit)
                            begin
                                rmag_next = add_digit(rmag_reg, rx_byte);
                            end
                            else
                            begin
                                phase_next = PH_DONE;
                            end
                        end
                        default:
                        begin
                            phase_next = phase_reg;
                        end
                    endcase
                end
            end
        end
        else
        begin
            // byte past capacity: drop the whole line
            stage_next.reply = REPLY_LONG;
            phase_next = PH_START;
            upper_next = 1'b0;
            ended_next = 1'b0;
            len_next = '0;
            lneg_next = 1'b0;
            lmag_next = '0;
            rneg_next = 1'b0;
            rmag_next = '0;
        end

        stage_next.stop = (elapsed_next > timeout_ms);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_START;
            upper_reg <= 1'b0;
            ended_reg <= 1'b0;
            len_reg <= '0;
            lneg_reg <= 1'b0;
            lmag_reg <= '0;
            rneg_reg <= 1'b0;
            rmag_reg <= '0;
            elapsed_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg <= phase_next;
                upper_reg <= upper_next;
                ended_reg <= ended_next;
                len_reg <= len_next;
                lneg_reg <= lneg_next;
                lmag_reg <= lmag_next;
                rneg_reg <= rneg_next;
                rmag_reg <= rmag_next;
                elapsed_reg <= elapsed_next;
                valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_reg <= stage_next;
        end
    end

    assign stage_valid = valid_reg;
    assign stage = stage_reg;

endmodule

`default_nettype wire

/* hw/rtl/sdcp_scale.sv */
`default_nettype none

module sdcp_scale
    import sdcp_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         advance,
    input  wire logic         stage_valid,
    input  wire sdcp_stage_t  stage,
    output logic              out_valid,
    output logic [1:0]        out_reply,
    output duty_set_t         out_duty
);

    localparam int QUOT_FULL_W = QUOT_IN_W + RECIP_W;

    logic [QUOT_FULL_W-1:0] left_quot;
    logic [QUOT_FULL_W-1:0] right_quot;
    logic [DUTY_W-1:0]      left_duty;
    logic [DUTY_W-1:0]      right_duty;

    duty_set_t  duty_reg, duty_next;
    logic       valid_reg;
    logic [1:0] reply_reg;
    duty_set_t  out_duty_reg;

    // divide by 100: drop two bits, then reciprocal multiply for the 25
    assign left_quot = QUOT_FULL_W'(stage.left_prod[PROD_W-1:2]) * QUOT_FULL_W'(DIV_RECIP);
    assign right_quot = QUOT_FULL_W'(stage.right_prod[PROD_W-1:2]) * QUOT_FULL_W'(DIV_RECIP);
    assign left_duty = left_quot[DIV_SHIFT +: DUTY_W];
    assign right_duty = right_quot[DIV_SHIFT +: DUTY_W];

    always_comb
    begin
        duty_next = duty_reg;
        if (stage.ok)
        begin
            duty_next[0] = (stage.left_nz && !stage.left_neg) ? left_duty : '0;
            duty_next[1] = (stage.left_nz && stage.left_neg) ? left_duty : '0;
            duty_next[2] = (stage.right_nz && !stage.right_neg) ? right_duty : '0;
            duty_next[3] = (stage.right_nz && stage.right_neg) ? right_duty : '0;
        end
        if (stage.stop)
        begin
            duty_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            duty_reg <= '0;
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= stage_valid;
            if (stage_valid)
            begin
                duty_reg <= duty_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && stage_valid)
        begin
            reply_reg <= stage.reply;
            out_duty_reg <= duty_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_reply = reply_reg;
    assign out_duty = out_duty_reg;

endmodule

`default_nettype wire

/* hw/rtl/serial_drive_command_parser_top.sv */
`default_nettype none

// Two-motor drive command parser. Each input transfer is either a received
// serial byte or a one-millisecond tick (s_tuser = 1); each gives exactly one
// output transfer with a reply code and the four current PWM compare values.
// Lines "L <int> R <int>" or "l <int> r <int>" end on CR or LF; a good line
// sets the duties to pwm_period_top * min(|speed|, limit) / 100 on the forward
// or reverse output, and the duties drop to zero once more ticks than the
// stop timeout register holds have passed since the last good line. One
// transfer is taken every cycle while m_tready does not stall the output; a
// result passes the parse stage (line state machine and the top-times-percent
// multiply) and then the scale stage (reciprocal multiply for the divide by
// 100). The user must write configuration only while no transfer is in
// flight; the block itself does not enforce it.
module serial_drive_command_parser_top
    import sdcp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // rx_byte
    input  wire logic        s_tuser,   // req_type
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // reply_code, left_fwd_duty, left_rev_duty, right_fwd_duty, right_rev_duty, zero pad
    output logic [71:0]      m_tdata,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    logic [DUTY_W-1:0] pwm_top_reg;
    logic [PCT_W-1:0]  pwm_limit_reg;
    logic [15:0]       timeout_reg;

    logic        advance;
    logic        accept;
    logic        stage_valid;
    sdcp_stage_t stage;
    logic [1:0]  out_reply;
    duty_set_t   out_duty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pwm_top_reg <= PWM_TOP_RESET;
            pwm_limit_reg <= PWM_LIMIT_RESET;
            timeout_reg <= TIMEOUT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_PWM_TOP:   pwm_top_reg <= cfg_data;
                CFG_PWM_LIMIT: pwm_limit_reg <= cfg_data[PCT_W-1:0];
                CFG_TIMEOUT:   timeout_reg <= cfg_data;
                default:       pwm_top_reg <= pwm_top_reg;
            endcase
        end
    end

    assign advance = !m_tvalid || m_tready;
    assign s_tready = !stage_valid || advance;
    assign accept = s_tvalid && s_tready;

    sdcp_parse u_parse (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .advance     (advance),
        .req_type    (s_tuser),
        .rx_byte     (s_tdata),
        .pwm_top     (pwm_top_reg),
        .pwm_limit   (pwm_limit_reg),
        .timeout_ms  (timeout_reg),
        .stage_valid (stage_valid),
        .stage       (stage)
    );

    sdcp_scale u_scale (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .stage_valid (stage_valid),
        .stage       (stage),
        .out_valid   (m_tvalid),
        .out_reply   (out_reply),
        .out_duty    (out_duty)
    );

    assign m_tdata = {6'd0, out_duty[3], out_duty[2], out_duty[1], out_duty[0], out_reply};

`ifndef SYNTH
    // a motor is never driven both ways at once
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (out_duty[0] == '0 || out_duty[1] == '0))
        else $error("left motor driven forward and reverse");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (out_duty[2] == '0 || out_duty[3] == '0))
        else $error("right motor driven forward and reverse");

    // a good line cannot also trip the timeout
    assert property (@(posedge clk) disable iff (!rst_n)
        (stage_valid && stage.ok) |-> !stage.stop)
        else $error("timeout on a good line");
`endif

endmodule

`default_nettype wire
